>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, muted during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, muted during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/ffha_pkg.sv
// Types and constants for the first-fit heap allocator
package ffha_pkg;
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_BAD_REL = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [12:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [12:0] data_offset;
        logic [1:0]  status;
        logic [12:0] idle_bytes;
    } t_out_item;
endpackage

>>> hw/rtl/ffha_ram.sv
// Generic single-port RAM with registered read
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> hw/rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing
//
// Usage: one input channel (i_in_valid/o_in_ready, payload i_in) carries
// allocate or release requests; one output channel (o_out_valid/i_out_ready,
// payload o_out) returns exactly one result item per request.
// Headers live in a single-port RAM with one entry per 4-byte heap word
// (valid, idle, data bytes, previous header word). A small sequencer does
// one RAM access per cycle. Zero size, oversize, null and malformed
// releases are answered from the idle state. An allocate walks the
// chain, reading each header and then checking its data; on a fit it
// writes any split's new header, then the chosen header, then fixes the
// back link of a block after the split. A release reads its header,
// rejecting it if invalid or idle, checks the next and previous blocks
// for merging, writes or clears its own header and fixes the following
// block's back link. The chain walk is bounded by the single RAM port.
// Reset: a clearing pass writes every RAM word once (HEAP_BYTES/4 cycles)
// and then the initial idle block at word 1; no item is taken meanwhile.
// The result sits in an output register; if the receiver stalls, the
// block holds it and takes no new item until it is taken.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES      = 6144,
    parameter int HEADER_BYTES    = 16,
    parameter int MIN_SPLIT_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);
    localparam int WORDS = HEAP_BYTES / 4;
    localparam int AW    = $clog2(WORDS);      // word address bits
    localparam int BW    = $clog2(HEAP_BYTES + 1); // byte values
    localparam int EW    = 2 + BW + AW;        // entry width
    localparam logic [AW-1:0] FIRST_W = AW'(1);
    localparam logic [BW-1:0] HDR_B   = BW'(HEADER_BYTES);
    localparam logic [BW-1:0] SPLIT_B = BW'(MIN_SPLIT_BYTES);
    localparam logic [BW-1:0] INIT_B  = BW'(HEAP_BYTES - 4 - HEADER_BYTES);
    localparam logic [BW-1:0] WORDS_B = BW'(WORDS);

    // sequencer states
    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_INIT   = 5'd1;
    localparam logic [4:0] S_IDLE   = 5'd2;
    localparam logic [4:0] S_A_RD   = 5'd3;
    localparam logic [4:0] S_A_CHK  = 5'd4;
    localparam logic [4:0] S_A_NRD  = 5'd5;
    localparam logic [4:0] S_A_NCHK = 5'd6;
    localparam logic [4:0] S_A_WNEW = 5'd7;
    localparam logic [4:0] S_A_WHDR = 5'd8;
    localparam logic [4:0] S_R_RD   = 5'd9;
    localparam logic [4:0] S_R_CHK  = 5'd10;
    localparam logic [4:0] S_R_NRD  = 5'd11;
    localparam logic [4:0] S_R_NCHK = 5'd12;
    localparam logic [4:0] S_R_PRD  = 5'd13;
    localparam logic [4:0] S_R_PCHK = 5'd14;
    localparam logic [4:0] S_R_WCUR = 5'd15;
    localparam logic [4:0] S_R_ARD  = 5'd16;
    localparam logic [4:0] S_R_ACHK = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    typedef struct packed {
        logic          valid;
        logic          idle;
        logic [BW-1:0] bytes;
        logic [AW-1:0] prev;
    } t_entry;

    logic [4:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [BW-1:0] r_idle_tot, n_idle_tot;
    logic [BW-1:0] r_size, n_size;   // rounded request
    logic [AW-1:0] r_w, n_w;         // current header word
    t_entry        r_cur, n_cur;     // copy of current header
    logic [AW-1:0] r_nw, n_nw;       // next / new header word
    logic [AW-1:0] r_keep, n_keep;   // surviving merged block word
    t_entry        r_kent, n_kent;
    logic [BW-1:0] r_after, n_after; // byte after merged/split block
    logic          r_split, n_split;
    logic          r_out_v, n_out_v;
    t_out_item     r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    t_entry        ram_wd, ram_rd;

    ffha_ram #(.WIDTH(EW), .DEPTH(WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wd),
        .o_rdata(ram_rd)
    );

    // byte end of block at word index w with data size b
    function automatic logic [BW+1:0] end_byte(logic [AW-1:0] w, logic [BW-1:0] b);
        return {w, 2'b00} + (BW+2)'(HDR_B) + (BW+2)'(b);
    endfunction

    logic [BW+1:0] e_cur, e_new, addr_hdr;
    logic [16:0]   rnd;              // request+2 rounded up, no wrap
    logic [BW:0]   spare;
    logic          fits;

    assign e_cur    = end_byte(r_w, ram_rd.bytes);
    assign e_new    = end_byte(r_w, r_size);
    assign fits     = ram_rd.valid && ram_rd.idle && (ram_rd.bytes >= r_size);
    assign spare    = {1'b0, ram_rd.bytes} - {1'b0, r_size};
    assign rnd      = (17'(i_in.request_bytes) + 17'(5)) & ~17'(3);
    assign addr_hdr = (BW+2)'(i_in.release_address) - (BW+2)'(HDR_B);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_idle_tot = r_idle_tot;
        n_size     = r_size;
        n_w        = r_w;
        n_cur      = r_cur;
        n_nw       = r_nw;
        n_keep     = r_keep;
        n_kent     = r_kent;
        n_after    = r_after;
        n_split    = r_split;
        n_out_v    = r_out_v;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_addr   = r_w;
        ram_wd     = '0;
        o_in_ready = 1'b0;

        if (r_out_v && i_out_ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_INIT;
                end
                n_clr = r_clr + AW'(1);
            end
            S_INIT: begin
                ram_we   = 1'b1;
                ram_addr = FIRST_W;
                ram_wd   = '{valid: 1'b1, idle: 1'b1, bytes: INIT_B, prev: '0};
                n_idle_tot = INIT_B;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = !r_out_v;
                if (i_in_valid && !r_out_v) begin
                    n_out.idle_bytes  = r_idle_tot[12:0];
                    n_out.data_offset = '0;
                    if (i_in.mode == MODE_ALLOC) begin
                        n_w = FIRST_W;
                        if (i_in.request_bytes == '0) begin
                            n_out.status = ST_ZERO;
                            n_out_v = 1'b1;
                        end else if (rnd > 17'(INIT_B)) begin
                            n_out.status = ST_NOFIT;
                            n_out_v = 1'b1;
                        end else begin
                            n_size  = rnd[BW-1:0];
                            n_state = S_A_RD;
                        end
                    end else begin
                        n_w = addr_hdr[AW+1:2];
                        if (i_in.release_address == '0) begin
                            n_out.status = ST_OK;
                            n_out_v = 1'b1;
                        end else if (i_in.release_address[1:0] != 2'b00
                                || (BW+2)'(i_in.release_address) < (BW+2)'(HEADER_BYTES + 4)
                                || addr_hdr[BW+1:2] >= (BW)'(WORDS)) begin
                            n_out.status = ST_BAD_REL;
                            n_out_v = 1'b1;
                        end else begin
                            n_state = S_R_RD;
                        end
                    end
                end
            end
            // ---------------- allocate walk ----------------
            S_A_RD: begin
                ram_addr = r_w;
                n_state  = S_A_CHK;
            end
            S_A_CHK: begin
                n_cur = ram_rd;
                if (!ram_rd.valid) begin
                    n_out.status = ST_NOFIT;
                    n_state = S_DONE;
                end else if (fits) begin
                    n_split = (spare >= (BW+1)'(SPLIT_B)) && (spare >= (BW+1)'(HDR_B));
                    n_after = e_cur[BW-1:0];
                    n_nw    = e_new[AW+1:2];
                    n_state = S_A_WHDR;
                    if ((spare >= (BW+1)'(SPLIT_B)) && (spare >= (BW+1)'(HDR_B))) begin
                        n_idle_tot = r_idle_tot - r_size - HDR_B;
                        n_state = S_A_WNEW;
                    end else begin
                        n_idle_tot = r_idle_tot - ram_rd.bytes;
                    end
                    n_out.status      = ST_OK;
                    n_out.data_offset = 13'(end_byte(r_w, '0));
                end else if (e_cur[BW+1:2] >= (BW)'(WORDS)) begin
                    n_out.status = ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    n_w     = e_cur[AW+1:2];
                    n_state = S_A_RD;
                end
            end
            S_A_WNEW: begin
                ram_we   = 1'b1;
                ram_addr = r_nw;
                ram_wd   = '{valid: 1'b1, idle: 1'b1,
                             bytes: BW'(r_cur.bytes - r_size - HDR_B), prev: r_w};
                n_state  = S_A_WHDR;
            end
            S_A_WHDR: begin
                ram_we   = 1'b1;
                ram_addr = r_w;
                ram_wd   = '{valid: 1'b1, idle: 1'b0,
                             bytes: (r_split ? r_size : r_cur.bytes), prev: r_cur.prev};
                n_keep   = r_nw;
                if (r_split && (r_after >> 2) < WORDS_B) begin
                    n_w     = r_after[AW+1:2];
                    n_state = S_R_ARD;
                end else begin
                    n_state = S_DONE;
                end
            end
            // ---------------- release ----------------
            S_R_RD: begin
                ram_addr = r_w;
                n_state  = S_R_CHK;
            end
            S_R_CHK: begin
                n_cur = ram_rd;
                if (!ram_rd.valid || ram_rd.idle) begin
                    n_out.status = ST_BAD_REL;
                    n_state = S_DONE;
                end else begin
                    n_out.status = ST_OK;
                    n_idle_tot = r_idle_tot + ram_rd.bytes;
                    n_after = e_cur[BW-1:0];
                    n_cur.idle = 1'b1;
                    if (e_cur[BW+1:2] < (BW)'(WORDS)) begin
                        n_nw = e_cur[AW+1:2];
                        n_state = S_R_NRD;
                    end else begin
                        n_state = S_R_PRD;
                    end
                end
            end
            S_R_NRD: begin
                ram_addr = r_nw;
                n_state  = S_R_NCHK;
            end
            S_R_NCHK: begin
                if (ram_rd.valid && ram_rd.idle) begin
                    // absorb next block, drop its header
                    ram_we   = 1'b1;
                    ram_addr = r_nw;
                    ram_wd   = '0;
                    n_cur.bytes = r_cur.bytes + HDR_B + ram_rd.bytes;
                    n_after  = r_after + HDR_B + ram_rd.bytes;
                    n_idle_tot = r_idle_tot + HDR_B;
                end
                n_state = S_R_PRD;
            end
            S_R_PRD: begin
                ram_addr = r_cur.prev;
                n_state  = S_R_PCHK;
            end
            S_R_PCHK: begin
                if (r_cur.prev != '0 && ram_rd.valid && ram_rd.idle) begin
                    ram_we   = 1'b1;
                    ram_addr = r_cur.prev;
                    ram_wd   = ram_rd;
                    ram_wd.bytes = ram_rd.bytes + HDR_B + r_cur.bytes;
                    n_keep   = r_cur.prev;
                    n_kent   = '0;
                    n_idle_tot = r_idle_tot + HDR_B;
                end else begin
                    n_keep   = r_w;
                    n_kent   = r_cur;
                end
                n_state = S_R_WCUR;
            end
            S_R_WCUR: begin
                ram_we   = 1'b1;
                ram_addr = r_w;
                ram_wd   = (r_keep == r_w) ? r_kent : '0;
                if ((r_after >> 2) < WORDS_B) begin
                    n_w     = r_after[AW+1:2];
                    n_state = S_R_ARD;
                end else begin
                    n_state = S_DONE;
                end
            end
            // fix back link of the block after the changed one
            S_R_ARD: begin
                ram_addr = r_w;
                n_state  = S_R_ACHK;
            end
            S_R_ACHK: begin
                if (ram_rd.valid) begin
                    ram_we   = 1'b1;
                    ram_addr = r_w;
                    ram_wd   = ram_rd;
                    ram_wd.prev = r_keep;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_out.idle_bytes = r_idle_tot[12:0];
                n_out_v = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_idle_tot <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_idle_tot <= n_idle_tot;
            r_out_v    <= n_out_v;
        end
        r_size  <= n_size;
        r_w     <= n_w;
        r_cur   <= n_cur;
        r_nw    <= n_nw;
        r_keep  <= n_keep;
        r_kent  <= n_kent;
        r_after <= n_after;
        r_split <= n_split;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
endmodule

>>> hw/rtl/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level
`include "assert_macros.svh"
module ffha_props
    import ffha_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);
    `ASSERT_IMPL(a_no_accept_while_full, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out))
    `ASSERT_IMPL(a_null_on_error, i_clk, i_rst_n,
        o_out_valid && o_out.status != ST_OK, o_out.data_offset == '0)
    `ASSERT_IMPL(a_offset_aligned, i_clk, i_rst_n, o_out_valid,
        o_out.data_offset[1:0] == 2'b00)
endmodule

bind first_fit_heap_allocator ffha_props u_ffha_props (.*);

>>> verif/ffha_checker.sv
// Checker for the heap allocator: predicts each result item and compares it with the result seen
module ffha_checker
    import ffha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_BYTES      = 6144;
    localparam int HEADER_BYTES    = 16;
    localparam int MIN_SPLIT_BYTES = 32;
    localparam int HEAP_WORDS      = HEAP_BYTES / 4;
    localparam int FIRST_HDR       = 4;

    // shadow header store, one entry per heap word
    bit hdr_valid [HEAP_WORDS];
    bit hdr_idle  [HEAP_WORDS];
    int hdr_bytes [HEAP_WORDS];
    int hdr_prev  [HEAP_WORDS];
    int idle_sum;

    t_out_item expected_results [$];

    assign o_pending = expected_results.size();

    function automatic bit header_at(int hdr);
        return ((hdr >> 2) < HEAP_WORDS) && hdr_valid[hdr >> 2];
    endfunction

    function automatic int block_end(int hdr);
        return hdr + HEADER_BYTES + hdr_bytes[hdr >> 2];
    endfunction

    function automatic void clear_heap();
        for (int k = 0; k < HEAP_WORDS; k++) begin
            hdr_valid[k] = 0;
            hdr_idle[k]  = 0;
            hdr_bytes[k] = 0;
            hdr_prev[k]  = 0;
        end
        hdr_valid[FIRST_HDR >> 2] = 1;
        hdr_idle[FIRST_HDR >> 2]  = 1;
        hdr_bytes[FIRST_HDR >> 2] = HEAP_BYTES - FIRST_HDR - HEADER_BYTES;
        idle_sum = hdr_bytes[FIRST_HDR >> 2];
    endfunction

    function automatic logic [1:0] take_first_fit(int req, output int offset);
        int size;
        int hdr;
        int w;
        int spare;
        int nh;
        int nw;
        int after;
        offset = 0;
        if (req == 0) return ST_ZERO;
        size = (req + 5) & ~3;
        hdr = FIRST_HDR;
        for (int n = 0; n < HEAP_WORDS && header_at(hdr); n++) begin
            w = hdr >> 2;
            if (hdr_idle[w] && hdr_bytes[w] >= size) begin
                spare = hdr_bytes[w] - size;
                if (spare >= MIN_SPLIT_BYTES && spare >= HEADER_BYTES) begin
                    nh = hdr + HEADER_BYTES + size;
                    nw = nh >> 2;
                    after = block_end(hdr);
                    if (nw < HEAP_WORDS) begin
                        hdr_valid[nw] = 1;
                        hdr_idle[nw]  = 1;
                        hdr_bytes[nw] = spare - HEADER_BYTES;
                        hdr_prev[nw]  = w;
                        if (header_at(after)) hdr_prev[after >> 2] = nw;
                    end
                    hdr_bytes[w] = size;
                    idle_sum -= size + HEADER_BYTES;
                end else begin
                    idle_sum -= hdr_bytes[w];
                end
                hdr_idle[w] = 0;
                offset = hdr + HEADER_BYTES;
                return ST_OK;
            end
            hdr = block_end(hdr);
        end
        return ST_NOFIT;
    endfunction

    function automatic logic [1:0] release_block(int addr);
        int hdr;
        int w;
        int nxt;
        int nw;
        int pw;
        int after;
        if (addr == 0) return ST_OK;
        if ((addr & 3) != 0 || addr < HEADER_BYTES + FIRST_HDR) return ST_BAD_REL;
        hdr = addr - HEADER_BYTES;
        if (!header_at(hdr)) return ST_BAD_REL;
        w = hdr >> 2;
        if (hdr_idle[w]) return ST_BAD_REL;
        hdr_idle[w] = 1;
        idle_sum += hdr_bytes[w];
        // merge with the following block
        nxt = block_end(hdr);
        if (header_at(nxt) && hdr_idle[nxt >> 2]) begin
            nw = nxt >> 2;
            hdr_bytes[w] += HEADER_BYTES + hdr_bytes[nw];
            hdr_valid[nw] = 0;
            hdr_idle[nw]  = 0;
            hdr_bytes[nw] = 0;
            hdr_prev[nw]  = 0;
            idle_sum += HEADER_BYTES;
            after = block_end(hdr);
            if (header_at(after)) hdr_prev[after >> 2] = w;
        end
        // merge into the preceding block
        pw = hdr_prev[w];
        if (pw != 0 && pw < HEAP_WORDS && hdr_valid[pw] && hdr_idle[pw]) begin
            hdr_bytes[pw] += HEADER_BYTES + hdr_bytes[w];
            hdr_valid[w] = 0;
            hdr_idle[w]  = 0;
            hdr_bytes[w] = 0;
            hdr_prev[w]  = 0;
            idle_sum += HEADER_BYTES;
            after = block_end(pw << 2);
            if (header_at(after)) hdr_prev[after >> 2] = pw;
        end
        return ST_OK;
    endfunction

    function automatic t_out_item heap_result(t_in_item it);
        t_out_item r;
        int offset;
        offset = 0;
        if (it.mode == MODE_ALLOC) r.status = take_first_fit(int'(it.request_bytes), offset);
        else r.status = release_block(int'(it.release_address));
        r.data_offset = offset[12:0];
        r.idle_bytes  = idle_sum[12:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_heap();
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) expected_results.push_back(heap_result(i_in));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.data_offset !== want.data_offset)
                        $error("data_offset expected %0d actual %0d",
                               want.data_offset, i_out.data_offset);
                    if (i_out.status !== want.status)
                        $error("status expected %0d actual %0d", want.status, i_out.status);
                    if (i_out.idle_bytes !== want.idle_bytes)
                        $error("idle_bytes expected %0d actual %0d",
                               want.idle_bytes, i_out.idle_bytes);
                    if (i_out !== want) o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

>>> verif/first_fit_heap_allocator_tb.sv
// Testbench top for the first-fit heap allocator: stimulus, idling phases and verdict
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int ITEMS_PER_SET = 240;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    logic      in_ready;
    t_in_item  in_item    = '0;
    logic      out_valid;
    logic      out_ready  = 1'b0;
    t_out_item out_item;

    int fail_count;
    int pending;
    int cycles     = 0;
    int sent       = 0;
    int returned   = 0;
    int idle_pct   = 0;   // sender gap odds, percent
    int stall_pct  = 0;   // receiver stall odds, percent
    int last_freed = 0;
    int live [$];         // data offsets currently held by the stimulus

    always #1 i_clk = ~i_clk;

    first_fit_heap_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    ffha_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver side: one ready decision per cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // track granted blocks so releases can target real ones
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            returned++;
            if (out_item.status == ST_OK && out_item.data_offset != 0)
                live.push_back(int'(out_item.data_offset));
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Valid stays high across back-to-back items; it drops only for a gap,
    // so it never takes two assignments in one step.
    task automatic send_item(input t_in_item it);
        if (in_valid && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!(in_valid && in_ready));
        sent++;
    endtask

    task automatic send_alloc(input int bytes);
        t_in_item it;
        it.mode            = MODE_ALLOC;
        it.request_bytes   = bytes[15:0];
        it.release_address = 13'($urandom_range(6143));
        send_item(it);
    endtask

    task automatic send_release(input int addr);
        t_in_item it;
        it.mode            = MODE_RELEASE;
        it.request_bytes   = 16'($urandom);
        it.release_address = addr[12:0];
        send_item(it);
    endtask

    // drop valid so the last item is not taken again, then wait for results
    task automatic drain();
        in_valid <= 1'b0;
        while (returned != sent) @(posedge i_clk);
    endtask

    task automatic random_item();
        int pick;
        int idx;
        pick = $urandom_range(99);
        if (pick < 52 || live.size() == 0) begin
            // mostly small blocks so the chain grows long; sometimes huge
            case ($urandom_range(19))
                0:       send_alloc($urandom_range(65535));
                1:       send_alloc(0);
                2:       send_alloc($urandom_range(300, 2000));
                default: send_alloc($urandom_range(1, 120));
            endcase
        end else if (pick < 85) begin
            idx = $urandom_range(live.size() - 1);
            last_freed = live[idx];
            live.delete(idx);
            send_release(last_freed);
        end else begin
            // noise: double release, null, misaligned or arbitrary address
            case ($urandom_range(3))
                0: send_release(last_freed);
                1: send_release(0);
                2: send_release(($urandom_range(1535) << 2) | $urandom_range(1, 3));
                default: send_release($urandom_range(6143));
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rounding, exact fit, no fit, each release reject and one-sided merges
        send_alloc(1);        // data 20
        send_alloc(10);       // data 40
        send_alloc(30);       // data 68
        send_alloc(100);      // data 116, tail idle block at 220
        send_alloc(0);
        send_alloc(65535);
        send_alloc(6000);
        send_alloc(5906);     // consumes the tail exactly, no split
        send_alloc(1);        // heap full
        send_release(40);     // neighbors in use
        send_release(68);     // merges into previous
        send_release(20);     // merges with next
        send_release(116);    // merges into previous
        send_release(20);     // already idle
        send_release(21);     // misaligned
        send_release(16);     // below first data offset
        send_release(6140);   // no header there
        send_release(0);      // null
        send_release(8188);   // beyond the heap
        send_release(236);    // tail block: heap back to one block
        send_alloc(6122);     // largest that fits
        send_release(20);
        drain();
        live.delete();

        for (int set = 0; set < 4; set++) begin
            case (set)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (int k = 0; k < ITEMS_PER_SET; k++) random_item();
        end
        stall_pct = 0;

        drain();
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> first_fit_heap_allocator.f
+incdir+hw/rtl
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/first_fit_heap_allocator.sv
hw/rtl/ffha_checker.sv
verif/ffha_checker.sv
verif/first_fit_heap_allocator_tb.sv
